### design/afsk_pkg.sv
`default_nettype none

package afsk_pkg;

	localparam int SAMPLE_BITS         = 16;
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;

	localparam int INC_BITS   = 32;
	localparam int ALPHA_BITS = 17;
	localparam int SPB_BITS   = 22;
	localparam int ERR_BITS   = 17;
	localparam int CNT_BITS   = 7;
	localparam int IDX_BITS   = 3;
	localparam int CFG_BITS   = 32;

	localparam logic [CNT_BITS-1:0] MAX_SAMPLES = 7'd64;
	localparam logic [ERR_BITS-1:0] ERR_SAT     = 17'd32767;

	localparam logic [INC_BITS-1:0]   RST_MARK  = 32'd107374182;
	localparam logic [INC_BITS-1:0]   RST_SPACE = 32'd196852668;
	localparam logic [ALPHA_BITS-1:0] RST_ALPHA = 17'd65536;
	localparam logic [SPB_BITS-1:0]   RST_SPB   = 22'd2621440;

	localparam logic [IDX_BITS-1:0] REG_MARK  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_SPACE = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_ALPHA = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SPB   = 3'd3;

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

	typedef struct packed {
		logic data_bit;
		logic restart;
	} bit_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} samp_item_t;

	typedef struct packed {
		logic start;
		logic mul;
		logic upd;
		logic phase;
		logic rom;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last;
		logic out_free;
	} dp_stat_t;

	// shift and subtract quotient, used only while building the table
	function automatic longint unsigned div_shift(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// cosine in q30 by truncated taylor series through x^22, clamped at zero
	function automatic longint unsigned cos_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		sum  = longint'(ONE_Q30);
		for (int n = 1; n <= 11; n++) begin
			term = (term * x2) >> 30;
			term = div_shift(term, longint'((2 * n - 1) * (2 * n)));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	// quarter-wave entry k for a table of 2^tab_bits steps
	function automatic logic [SAMPLE_BITS-1:0] cos_entry(input int k, input int tab_bits);
		longint unsigned amp;
		longint unsigned x;
		longint unsigned c;
		longint unsigned v;
		amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		x   = (longint'(k) * PI_HALF_Q30) >> tab_bits;
		c   = cos_q30(x);
		v   = (amp * c + (ONE_Q30 >> 1)) >> 30;
		if (k == 0) begin
			v = amp;
		end else if (k == (1 << tab_bits)) begin
			v = 64'd0;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### design/afsk_ctrl.sv
`default_nettype none

module afsk_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 bit_valid,
	output logic                bit_ready,
	input  afsk_pkg::dp_stat_t  st,
	output afsk_pkg::dp_cmd_t   cmd
);
	import afsk_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_UPD,
		S_PHASE,
		S_ROM,
		S_LOAD
	} state_t;

	state_t state_q;

	assign bit_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.start = (state_q == S_IDLE) && bit_valid;
		cmd.mul   = (state_q == S_MUL);
		cmd.upd   = (state_q == S_UPD);
		cmd.phase = (state_q == S_PHASE);
		cmd.rom   = (state_q == S_ROM);
		cmd.load  = (state_q == S_LOAD) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (bit_valid && !st.n_zero) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_UPD;
				S_UPD:   state_q <= S_PHASE;
				S_PHASE: state_q <= S_ROM;
				S_ROM:   state_q <= S_LOAD;
				S_LOAD: begin
					if (st.out_free) begin
						state_q <= st.last ? S_IDLE : S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && st.last |=> state_q == S_IDLE)
		else $error("bit period did not end after final sample");

	a_next_sample: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !st.last |=> state_q == S_MUL)
		else $error("next sample not started");

	a_hold_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && !st.out_free |=> state_q == S_LOAD)
		else $error("left load state while output register full");

endmodule

`default_nettype wire

### design/afsk_dp.sv
`default_nettype none

module afsk_dp #(
	parameter int PHASE_BITS      = afsk_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = afsk_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [afsk_pkg::IDX_BITS-1:0]        cfg_index,
	input  wire [afsk_pkg::CFG_BITS-1:0]        cfg_data,
	input  afsk_pkg::bit_item_t                 bit_item,
	input  afsk_pkg::dp_cmd_t                   cmd,
	output afsk_pkg::dp_stat_t                  st,
	output logic                                samp_valid,
	input  wire                                 samp_ready,
	output afsk_pkg::samp_item_t                samp_item
);
	import afsk_pkg::*;

	localparam int QUARTER = 1 << TABLE_ADDR_BITS;
	localparam logic [TABLE_ADDR_BITS:0] QTR = (TABLE_ADDR_BITS + 1)'(QUARTER);

	typedef logic [SAMPLE_BITS-1:0] tab_t [QUARTER+1];

	function automatic tab_t build_tab();
		tab_t t;
		for (int k = 0; k <= QUARTER; k++) begin
			t[k] = cos_entry(k, TABLE_ADDR_BITS);
		end
		return t;
	endfunction

	localparam tab_t COS_TAB = build_tab();

	// configuration registers
	logic [INC_BITS-1:0]   mark_q;
	logic [INC_BITS-1:0]   space_q;
	logic [ALPHA_BITS-1:0] alpha_q;
	logic [SPB_BITS-1:0]   spb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= RST_MARK;
			space_q <= RST_SPACE;
			alpha_q <= RST_ALPHA;
			spb_q   <= RST_SPB;
		end else if (cfg_we) begin
			if (cfg_index == REG_MARK)  mark_q  <= cfg_data[INC_BITS-1:0];
			if (cfg_index == REG_SPACE) space_q <= cfg_data[INC_BITS-1:0];
			if (cfg_index == REG_ALPHA) alpha_q <= cfg_data[ALPHA_BITS-1:0];
			if (cfg_index == REG_SPB)   spb_q   <= cfg_data[SPB_BITS-1:0];
		end
	end

	// bit period count with error carry, rounded half up
	logic signed [ERR_BITS-1:0] err_q;
	logic [CNT_BITS-1:0]        left_q;
	logic                       bit_q;
	logic signed [23:0]         w;
	logic [CNT_BITS-1:0]        n_raw;
	logic [CNT_BITS-1:0]        n_cnt;
	logic [ERR_BITS-1:0]        err_new;

	always_comb begin
		w = $signed({2'b00, spb_q}) + 24'(err_q) + 24'sd32768;
		n_raw = w[22:16];
		if (n_raw > MAX_SAMPLES) begin
			n_cnt   = MAX_SAMPLES;
			err_new = ERR_SAT;
		end else begin
			n_cnt   = n_raw;
			err_new = {~w[15], ~w[15], w[14:0]};
		end
	end

	// smoothing: old + round(a * (target - old) / 2^16)
	logic [INC_BITS-1:0]          smooth_q;
	logic [PHASE_BITS-1:0]        phase_q;
	logic signed [50:0]           prod_q;
	logic [ALPHA_BITS-1:0]        a_sat;
	logic [INC_BITS-1:0]          target;
	logic signed [INC_BITS:0]     diff;
	logic signed [50:0]           rsum;
	logic [PHASE_BITS+INC_BITS-1:0] inc_ext;

	assign a_sat   = alpha_q[ALPHA_BITS-1] ? RST_ALPHA : alpha_q;
	assign target  = bit_q ? mark_q : space_q;
	assign diff    = $signed({1'b0, target}) - $signed({1'b0, smooth_q});
	assign rsum    = prod_q + 51'sd32768;
	assign inc_ext = {PHASE_BITS'(0), smooth_q};

	// table address from the top phase bits
	logic [TABLE_ADDR_BITS+1:0] top;
	logic [TABLE_ADDR_BITS:0]   addr;
	logic [SAMPLE_BITS-1:0]     rom_s1;
	logic                       neg_s1;

	assign top  = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
	assign addr = top[TABLE_ADDR_BITS] ? (QTR - {1'b0, top[TABLE_ADDR_BITS-1:0]})
	                                   : {1'b0, top[TABLE_ADDR_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q    <= '0;
			left_q   <= '0;
			bit_q    <= 1'b0;
			smooth_q <= RST_MARK;
			phase_q  <= '0;
		end else begin
			if (cmd.start) begin
				err_q  <= err_new;
				left_q <= n_cnt;
				bit_q  <= bit_item.data_bit;
				if (bit_item.restart) begin
					phase_q  <= '0;
					smooth_q <= mark_q;
				end
			end
			if (cmd.upd) begin
				smooth_q <= smooth_q + rsum[47:16];
			end
			if (cmd.phase) begin
				phase_q <= phase_q + inc_ext[PHASE_BITS-1:0];
			end
			if (cmd.load) begin
				left_q <= left_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= $signed({1'b0, a_sat}) * diff;
		end
		if (cmd.rom) begin
			rom_s1 <= COS_TAB[addr];
			neg_s1 <= top[TABLE_ADDR_BITS+1] ^ top[TABLE_ADDR_BITS];
		end
	end

	// output register, takes a new sample as the old one transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_valid <= 1'b0;
		end else if (cmd.load) begin
			samp_valid <= 1'b1;
		end else if (samp_ready) begin
			samp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			samp_item.sample <= neg_s1 ? -$signed(rom_s1) : $signed(rom_s1);
			samp_item.last   <= (left_q == CNT_BITS'(1));
		end
	end

	assign st.n_zero   = (n_cnt == '0);
	assign st.last     = (left_q == CNT_BITS'(1));
	assign st.out_free = !samp_valid || samp_ready;

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= MAX_SAMPLES)
		else $error("sample count above limit");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		err_q >= -17'sd32768 && err_q <= 17'sd32767)
		else $error("timing error carry out of range");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> samp_valid)
		else $error("loaded sample not presented");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> left_q != '0)
		else $error("sample loaded with no samples left");

endmodule

`default_nettype wire

### design/afsk_dds_bit_modulator.sv
// each sample of a bit passes the controller states multiply, smoothing update,
// phase step, registered cosine table read and load; the load waits while the
// output register still holds an untransferred sample, and a new bit is taken
// only after the last sample of the current bit is loaded
// reset: asynchronous, registers return to defaults, phase and carry cleared
`default_nettype none

module afsk_dds_bit_modulator #(
	parameter int PHASE_BITS      = afsk_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = afsk_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [afsk_pkg::IDX_BITS-1:0] cfg_index,
	input  wire [afsk_pkg::CFG_BITS-1:0] cfg_data,
	input  wire                          bit_valid,
	output logic                         bit_ready,
	input  afsk_pkg::bit_item_t          bit_item,
	output logic                         samp_valid,
	input  wire                          samp_ready,
	output afsk_pkg::samp_item_t         samp_item
);
	import afsk_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	afsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.bit_valid (bit_valid),
		.bit_ready (bit_ready),
		.st        (st),
		.cmd       (cmd)
	);

	afsk_dp #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.bit_item   (bit_item),
		.cmd        (cmd),
		.st         (st),
		.samp_valid (samp_valid),
		.samp_ready (samp_ready),
		.samp_item  (samp_item)
	);

endmodule

`default_nettype wire
